// File: hdl/gsp_pkg.sv
// Grid scan path generator package: widths, codes, shared types and the
// geometry and path-start functions. No dependencies.
`default_nettype none

package gsp_pkg;

    localparam int MAX_DIM    = 256;
    localparam int CRD_W      = $clog2(MAX_DIM) + 2;
    localparam int CNT_W      = $clog2(MAX_DIM) + 1;
    localparam int DIM_W      = 9;
    localparam int OFF_W      = 8;
    localparam int OUT_W      = 9;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    typedef logic signed [CRD_W-1:0] t_crd;
    typedef logic [CNT_W-1:0]        t_cnt;

    localparam t_crd CRD_ONE = t_crd'(1);
    localparam t_crd CRD_TWO = t_crd'(2);
    localparam t_cnt CNT_ONE = t_cnt'(1);

    typedef enum logic [MODE_W-1:0] {
        MODE_ROW    = 2'd0,
        MODE_SPIRAL = 2'd1,
        MODE_STRIP  = 2'd2,
        MODE_HYBRID = 2'd3
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATH_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET    = 3'd4;

    localparam logic [DIM_W-1:0] RST_GRID_WIDTH  = 9'd8;
    localparam logic [DIM_W-1:0] RST_GRID_HEIGHT = 9'd8;
    localparam t_mode            RST_PATH_MODE   = MODE_ROW;
    localparam logic [OFF_W-1:0] RST_OFFSET      = 8'd0;

    typedef enum logic [5:0] {
        PH_ROW   = 6'b000001,
        PH_COL   = 6'b000010,
        PH_STRIP = 6'b000100,
        PH_SPX   = 6'b001000,
        PH_SPY   = 6'b010000,
        PH_FINAL = 6'b100000
    } t_phase;

    typedef struct packed {
        t_crd   pos_x;
        t_crd   pos_y;
        t_crd   seg_end;
        t_phase phase;
        logic   neg;
        t_cnt   corner;
        logic   done;
    } t_walk;

    typedef struct packed {
        t_crd w;
        t_crd h;
        t_crd sn;
        t_crd sp;
        t_crd sox;
        t_crd soy;
        t_crd qn;
        t_crd qp;
        t_crd m;
        t_crd strip_top;
        logic has_strip;
        logic row_mode;
        logic spiral_after;
    } t_geom;

    typedef struct packed {
        t_geom            geom;
        t_walk            start;
        t_walk            spiral;
        logic [OFF_W-1:0] x_off;
        logic [OFF_W-1:0] y_off;
        logic             restart;
    } t_cfg;

    typedef struct packed {
        logic [OUT_W-1:0] coord_x;
        logic [OUT_W-1:0] coord_y;
        logic             last_point;
    } t_res;

    function automatic t_crd f_eff_dim(logic [DIM_W-1:0] v);
        t_crd d;
        d = t_crd'(v);
        if (v == '0) begin
            d = CRD_ONE;
        end else if (d > t_crd'(MAX_DIM)) begin
            d = t_crd'(MAX_DIM);
        end
        return d;
    endfunction

    function automatic t_crd f_min(t_crd a, t_crd b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_geom f_geom(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, t_mode mode);
        t_geom g;
        t_crd  s;
        g.w            = f_eff_dim(w);
        g.h            = f_eff_dim(h);
        s              = f_min(g.w, g.h);
        g.qn           = g.w;
        g.qp           = g.h;
        g.sn           = g.w;
        g.sp           = g.h;
        g.sox          = '0;
        g.soy          = '0;
        g.has_strip    = (mode == MODE_STRIP);
        g.row_mode     = (mode == MODE_ROW);
        g.spiral_after = (mode == MODE_HYBRID);
        if (mode == MODE_HYBRID) begin
            g.qn        = s;
            g.qp        = s;
            g.has_strip = (g.w != g.h);
            if (g.w < g.h) begin
                g.sp  = g.h - s;
                g.soy = s;
            end else begin
                g.sn  = g.w - s;
                g.sox = s;
            end
        end
        g.m         = f_min(g.qn, g.qp);
        g.strip_top = g.soy + g.sp - CRD_ONE;
        return g;
    endfunction

    function automatic t_walk f_spiral(t_geom g);
        t_walk p;
        p.pos_x  = '0;
        p.pos_y  = '0;
        p.neg    = 1'b0;
        p.corner = '0;
        p.done   = 1'b0;
        if (g.qn > CRD_ONE) begin
            p.seg_end = g.qn - CRD_TWO;
            p.phase   = PH_SPX;
        end else if (g.qp > CRD_ONE) begin
            p.seg_end = g.qp - CRD_TWO;
            p.phase   = PH_SPY;
        end else begin
            p.seg_end = '0;
            p.neg     = 1'b1;
            p.corner  = CNT_ONE;
            p.phase   = PH_FINAL;
        end
        return p;
    endfunction

    function automatic t_walk f_start(t_geom g);
        t_walk p;
        p        = f_spiral(g);
        if (g.row_mode) begin
            p.pos_x   = '0;
            p.pos_y   = g.h - CRD_ONE;
            p.seg_end = g.w - CRD_ONE;
            p.phase   = PH_ROW;
            p.neg     = 1'b0;
            p.corner  = '0;
        end else if (g.has_strip) begin
            p.pos_x  = g.sox + g.sn - CRD_ONE;
            p.neg    = 1'b0;
            p.corner = '0;
            if (g.sn[0]) begin
                p.pos_y   = g.soy;
                p.seg_end = g.strip_top;
                p.phase   = PH_COL;
            end else begin
                p.pos_y   = g.strip_top;
                p.seg_end = g.sox + g.sn - CRD_TWO;
                p.phase   = PH_STRIP;
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// File: hdl/gsp_cfg.sv
// Configuration registers with registered path geometry and start points.
// Depends on gsp_pkg.
`default_nettype none

module gsp_cfg (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    input  wire [gsp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [gsp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output gsp_pkg::t_cfg                    o_cfg
);
    import gsp_pkg::*;

    logic [DIM_W-1:0] r_width,  n_width;
    logic [DIM_W-1:0] r_height, n_height;
    t_mode            r_mode,   n_mode;
    logic [OFF_W-1:0] r_x_off,  n_x_off;
    logic [OFF_W-1:0] r_y_off,  n_y_off;
    t_geom            r_geom,   n_geom;
    t_walk            r_start;
    t_walk            r_spiral;
    logic             restart;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_mode   = r_mode;
        n_x_off  = r_x_off;
        n_y_off  = r_y_off;
        restart  = 1'b0;
        if (!i_rst_n) begin
            n_width  = RST_GRID_WIDTH;
            n_height = RST_GRID_HEIGHT;
            n_mode   = RST_PATH_MODE;
            n_x_off  = RST_OFFSET;
            n_y_off  = RST_OFFSET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH: begin
                    n_width = i_cfg_data[DIM_W-1:0];
                    restart = 1'b1;
                end
                CFG_GRID_HEIGHT: begin
                    n_height = i_cfg_data[DIM_W-1:0];
                    restart  = 1'b1;
                end
                CFG_PATH_MODE: begin
                    n_mode  = t_mode'(i_cfg_data[MODE_W-1:0]);
                    restart = 1'b1;
                end
                CFG_X_OFFSET: n_x_off = i_cfg_data[OFF_W-1:0];
                CFG_Y_OFFSET: n_y_off = i_cfg_data[OFF_W-1:0];
                default: ;
            endcase
        end
        n_geom = f_geom(n_width, n_height, n_mode);
    end

    always_ff @(posedge i_clk) begin
        r_width  <= n_width;
        r_height <= n_height;
        r_mode   <= n_mode;
        r_x_off  <= n_x_off;
        r_y_off  <= n_y_off;
        r_geom   <= n_geom;
        r_start  <= f_start(n_geom);
        r_spiral <= f_spiral(n_geom);
    end

    assign o_cfg = '{
        geom:    r_geom,
        start:   r_start,
        spiral:  r_spiral,
        x_off:   r_x_off,
        y_off:   r_y_off,
        restart: restart
    };

endmodule

`default_nettype wire

// File: hdl/gsp_walk.sv
// Path state and combinational step to the next point; emits one result per
// advancing transfer. Depends on gsp_pkg.
`default_nettype none

module gsp_walk (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  wire                  i_advance,
    input  wire                  i_restart,
    input  wire gsp_pkg::t_cfg   i_cfg,
    output logic                 o_push,
    output gsp_pkg::t_res        o_res
);
    import gsp_pkg::*;

    t_walk r_walk, n_walk;
    logic  r_pending;
    t_walk cur, nxt;
    t_geom g;
    logic  ok;
    logic  along_y;
    t_crd  c, c_step, dir;
    t_crd  sp_len, sp_end;
    t_crd  turn_x, turn_y, turn_run, turn_end;
    t_cnt  ci1;

    always_comb begin
        g        = i_cfg.geom;
        cur      = (r_pending || i_restart) ? i_cfg.start : r_walk;
        nxt      = cur;
        ok       = 1'b1;
        along_y  = (cur.phase == PH_COL) || (cur.phase == PH_SPY);
        c        = along_y ? cur.pos_y : cur.pos_x;
        c_step   = (c < cur.seg_end) ? c + CRD_ONE : c - CRD_ONE;
        dir      = cur.neg ? -CRD_ONE : CRD_ONE;
        ci1      = cur.corner + CNT_ONE;
        sp_len   = g.qp - t_crd'(cur.corner) - CRD_ONE;
        sp_end   = cur.neg ? cur.pos_y - (sp_len - CRD_ONE) : cur.pos_y + (sp_len - CRD_ONE);
        turn_x   = (cur.phase == PH_SPX) ? cur.pos_x + dir : cur.pos_x;
        turn_y   = (cur.phase == PH_SPX) ? cur.pos_y : cur.pos_y + dir;
        turn_run = g.qn - t_crd'(ci1) - CRD_ONE;
        turn_end = cur.neg ? turn_x + turn_run : turn_x - turn_run;

        if (cur.phase == PH_FINAL) begin
            ok = 1'b0;
        end else if (c != cur.seg_end) begin
            if (along_y) begin
                nxt.pos_y = c_step;
            end else begin
                nxt.pos_x = c_step;
            end
        end else begin
            unique case (cur.phase)
                PH_ROW: begin
                    nxt.corner = ci1;
                    if (t_crd'(ci1) >= g.h) begin
                        ok = 1'b0;
                    end else begin
                        nxt.pos_y = g.h - CRD_ONE - t_crd'(ci1);
                        if (ci1[0]) begin
                            nxt.pos_x   = g.w - CRD_ONE;
                            nxt.seg_end = '0;
                        end else begin
                            nxt.pos_x   = '0;
                            nxt.seg_end = g.w - CRD_ONE;
                        end
                    end
                end
                PH_COL, PH_STRIP: begin
                    if (cur.phase == PH_STRIP && cur.pos_y > g.soy) begin
                        nxt.pos_y = cur.pos_y - CRD_ONE;
                        nxt.pos_x = cur.seg_end + CRD_ONE;
                    end else if (cur.pos_x - g.sox >= CRD_TWO) begin
                        nxt.pos_x   = cur.pos_x - CRD_ONE;
                        nxt.pos_y   = g.strip_top;
                        nxt.seg_end = cur.pos_x - CRD_TWO;
                        nxt.phase   = PH_STRIP;
                    end else if (g.spiral_after) begin
                        nxt = i_cfg.spiral;
                    end else begin
                        ok = 1'b0;
                    end
                end
                PH_SPX, PH_SPY: begin
                    if (cur.phase == PH_SPX && sp_len > t_crd'(0)) begin
                        nxt.pos_x   = cur.pos_x + dir;
                        nxt.seg_end = sp_end;
                        nxt.phase   = PH_SPY;
                    end else begin
                        nxt.neg    = ~cur.neg;
                        nxt.corner = ci1;
                        nxt.pos_x  = turn_x;
                        nxt.pos_y  = turn_y;
                        if (t_crd'(ci1) >= g.m) begin
                            nxt.phase = PH_FINAL;
                        end else begin
                            nxt.seg_end = turn_end;
                            nxt.phase   = PH_SPX;
                        end
                    end
                end
                default: ok = 1'b0;
            endcase
        end

        n_walk = cur;
        if (i_advance && !cur.done) begin
            if (ok) begin
                n_walk = nxt;
            end else begin
                n_walk.done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b1;
        end else if (i_cfg.restart) begin
            r_pending <= 1'b1;
        end else if (i_accept) begin
            r_pending <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_walk <= n_walk;
        end
    end

    assign o_push           = i_accept && i_advance;
    assign o_res.coord_x    = cur.pos_x[OUT_W-1:0] + OUT_W'(i_cfg.x_off);
    assign o_res.coord_y    = cur.pos_y[OUT_W-1:0] + OUT_W'(i_cfg.y_off);
    assign o_res.last_point = cur.done || !ok;

endmodule

`default_nettype wire

// File: hdl/gsp_skid.sv
// Result register with a skid stage that takes one more result while a
// result waits, and raises o_full once the skid stage holds a result. Depends on gsp_pkg.
`default_nettype none

module gsp_skid (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire gsp_pkg::t_res   i_res,
    input  wire                  i_stall,
    output logic                 o_valid,
    output gsp_pkg::t_res        o_res,
    output logic                 o_full
);
    import gsp_pkg::*;

    logic r_main_valid;
    logic r_skid_valid;
    t_res r_main;
    t_res r_skid;
    logic drain;

    assign drain = !r_main_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (drain) begin
            r_main_valid <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            r_main <= r_skid_valid ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    assign o_valid = r_main_valid;
    assign o_res   = r_main;
    assign o_full  = r_skid_valid;

endmodule

`default_nettype wire

// File: hdl/grid_scan_path_generator.sv
// A result is registered in the result stage, or in the skid stage while the output stalls.
// Throughput: one transfer per cycle while o_stall is low; the path step is one combinational pass
// from the state register to the result register, backed by a skid stage.
// Reset: registers return to an 8x8 row serpentine with zero offsets and the
// path restarts at its first point; the result and skid stages empty.
// Top level: ties the configuration, path walker and result stage together.
`default_nettype none

module grid_scan_path_generator (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire                              i_advance,
    input  wire                              i_restart,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [gsp_pkg::OUT_W-1:0]        o_coord_x,
    output logic [gsp_pkg::OUT_W-1:0]        o_coord_y,
    output logic                             o_last_point,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [gsp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [gsp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import gsp_pkg::*;

    t_cfg cfg;
    t_res walk_res;
    t_res out_res;
    logic push;
    logic full;
    logic accept;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full;
    assign accept      = i_valid && !full;

    gsp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gsp_walk u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_advance (i_advance),
        .i_restart (i_restart),
        .i_cfg     (cfg),
        .o_push    (push),
        .o_res     (walk_res)
    );

    gsp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (walk_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (out_res),
        .o_full  (full)
    );

    assign o_coord_x    = out_res.coord_x;
    assign o_coord_y    = out_res.coord_y;
    assign o_last_point = out_res.last_point;

endmodule

`default_nettype wire

// File: hdl/gsp_checker.sv
// Port-level checks for the grid scan path generator, bound to the top level.
// Depends on gsp_pkg.
`default_nettype none

module gsp_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_valid,
    input wire                              o_stall,
    input wire                              i_advance,
    input wire                              o_valid,
    input wire                              i_stall,
    input wire [gsp_pkg::OUT_W-1:0]         o_coord_x,
    input wire [gsp_pkg::OUT_W-1:0]         o_coord_y,
    input wire                              o_last_point
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result stage not empty after reset");

    a_advance_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_advance |=> o_valid)
        else $error("advancing transfer produced no result");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with no result waiting");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_coord_x) && $stable(o_coord_y)
            && $stable(o_last_point))
        else $error("stalled result changed");

endmodule

bind grid_scan_path_generator gsp_checker u_gsp_checker (.*);

`default_nettype wire
